// File: hw/rtl/melodic_tension_analyzer_core_defines.svh
// Assertion macros for the melodic tension analyser core.
`ifndef MELODIC_TENSION_ANALYZER_CORE_DEFINES_SVH
`define MELODIC_TENSION_ANALYZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define MTA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("melodic tension analyser: assertion failed");

// Next-cycle implication, disabled while reset is low.
`define MTA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("melodic tension analyser: assertion failed");

`endif

// File: hw/rtl/mta_pkg.sv
// Shared types, constants and control structs for the melodic tension analyser.
`default_nettype none

package mta_pkg;

    localparam int unsigned NoteW    = 8;
    localparam int unsigned PrevW    = 7;
    localparam int unsigned PcW      = 4;
    localparam int unsigned LevelW   = 3;
    localparam int unsigned FixW     = 21;
    localparam int unsigned IntvW    = 8;
    localparam int unsigned CfgIdxW  = 4;
    localparam int unsigned CfgDataW = 4;
    localparam int unsigned DivNumW  = 21;
    localparam int unsigned DivDenW  = 11;
    localparam int unsigned NumDeg   = 7;

    // register map
    typedef enum logic [CfgIdxW-1:0] {
        REG_TONIC_OFFSET = 4'd0,
        REG_TONIC_PC     = 4'd1,
        REG_SECOND_PC    = 4'd2,
        REG_THIRD_PC     = 4'd3,
        REG_FOURTH_PC    = 4'd4,
        REG_FIFTH_PC     = 4'd5,
        REG_SIXTH_PC     = 4'd6,
        REG_SEVENTH_PC   = 4'd7
    } t_reg_idx;

    localparam logic [CfgDataW-1:0] OffsetReset = 4'd0;
    localparam logic [CfgDataW-1:0] DegreeReset [NumDeg] = '{
        4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11
    };

    // basic-space levels
    localparam logic [LevelW-1:0] LevelOctave    = 3'd4;
    localparam logic [LevelW-1:0] LevelTriadic   = 3'd3;
    localparam logic [LevelW-1:0] LevelDiatonic  = 3'd2;
    localparam logic [LevelW-1:0] LevelChromatic = 3'd1;

    typedef enum logic [1:0] {
        OP_TENSION,
        OP_RATIO,
        OP_RBI
    } t_div_op;

    typedef struct packed {
        logic    capture;
        logic    prep;
        logic    div_start;
        t_div_op div_op;
        logic    load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_status;

endpackage

`default_nettype wire

// File: hw/rtl/mta_div.sv
// Restoring unsigned divider, two quotient bits per cycle.
`default_nettype none

module mta_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [mta_pkg::DivNumW-1:0]  i_dividend,
    input  wire logic [mta_pkg::DivDenW-1:0]  i_divisor,
    output logic                              o_done,
    output logic [mta_pkg::DivNumW-1:0]       o_quotient
);

    localparam int unsigned PadW  = mta_pkg::DivNumW + 1;
    localparam int unsigned Steps = PadW / 2;
    localparam int unsigned CntW  = $clog2(Steps);
    localparam logic [CntW-1:0] LastStep = CntW'(Steps - 1);
    localparam int unsigned DenW  = mta_pkg::DivDenW;

    logic            r_busy;
    logic            r_done;
    logic [CntW-1:0] r_cnt;
    logic [DenW-1:0] r_rem;
    logic [DenW-1:0] r_den;
    logic [PadW-1:0] r_num;
    logic [PadW-1:0] r_quo;

    logic [DenW:0]   w_t1, w_d1, w_t2, w_d2;
    logic            w_q1, w_q2;
    logic [DenW-1:0] w_rem1, w_rem2;

    always_comb begin
        w_t1   = {r_rem, r_num[PadW-1]};
        w_d1   = w_t1 - {1'b0, r_den};
        w_q1   = (w_t1 >= {1'b0, r_den});
        w_rem1 = w_q1 ? w_d1[DenW-1:0] : w_t1[DenW-1:0];
        w_t2   = {w_rem1, r_num[PadW-2]};
        w_d2   = w_t2 - {1'b0, r_den};
        w_q2   = (w_t2 >= {1'b0, r_den});
        w_rem2 = w_q2 ? w_d2[DenW-1:0] : w_t2[DenW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == LastStep) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_divisor;
            r_num <= {1'b0, i_dividend};
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_rem2;
            r_num <= {r_num[PadW-3:0], 2'b00};
            r_quo <= {r_quo[PadW-3:0], w_q1, w_q2};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo[mta_pkg::DivNumW-1:0];

endmodule

`default_nettype wire

// File: hw/rtl/mta_datapath.sv
// Datapath: config registers, pitch classification, divider operands and result registers.
`default_nettype none

module mta_datapath (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [mta_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [mta_pkg::CfgDataW-1:0]      i_cfg_data,
    input  wire logic [mta_pkg::NoteW-1:0]         i_note_number,
    input  wire mta_pkg::t_ctrl_cmd                i_cmd,
    output mta_pkg::t_dp_status                    o_status,
    output logic [mta_pkg::PcW-1:0]                o_pitch_class,
    output logic [mta_pkg::LevelW-1:0]             o_space_level,
    output logic                                   o_closure,
    output logic [mta_pkg::FixW-1:0]               o_tension,
    output logic [mta_pkg::FixW-1:0]               o_level_ratio,
    output logic [mta_pkg::FixW-1:0]               o_ratio_by_interval,
    output logic signed [mta_pkg::IntvW-1:0]       o_interval
);

    localparam int unsigned PrevW = mta_pkg::PrevW;
    localparam int unsigned LvW   = mta_pkg::LevelW;
    localparam int unsigned PcW   = mta_pkg::PcW;
    localparam int unsigned XW    = 9;
    localparam int unsigned PrW   = 17;
    localparam logic [PrW-1:0] Recip12    = 17'd171;
    localparam int unsigned    RecipShift = 11;
    localparam logic [XW-1:0]  TwoOctaves = 9'd24;
    localparam logic [XW-1:0]  Semis      = 9'd12;

    // configuration
    logic [mta_pkg::CfgDataW-1:0] r_tonic_offset;
    logic [mta_pkg::CfgDataW-1:0] r_deg [mta_pkg::NumDeg];
    logic [2:0]                   w_deg_idx;

    // history
    logic [PrevW-1:0] r_prev_note;
    logic [LvW-1:0]   r_prev_level;

    // per-word working registers
    logic [PrevW-1:0]                r_note;
    logic [PcW-1:0]                  r_pc;
    logic [LvW-1:0]                  r_s2, r_s1;
    logic [4:0]                      r_s2sq, r_s1sq;
    logic [PrevW-1:0]                r_span;
    logic [mta_pkg::IntvW-1:0]       r_interval;
    logic [mta_pkg::FixW-1:0]        r_q_tension, r_q_ratio, r_q_rbi;

    logic [mta_pkg::IntvW-1:0] w_interval, w_abs;
    logic [PrevW-1:0]          w_span;
    logic [XW-1:0]             w_x, w_q12, w_rem;
    logic [PrW-1:0]            w_prod;
    logic [3:0]                w_quo;
    logic [PcW-1:0]            w_pc;
    logic [LvW-1:0]            w_s2, w_s1;
    logic [4:0]                w_s2sq, w_s1sq;
    logic [9:0]                w_s1d;
    logic [11:0]               w_s1sqd;
    logic [mta_pkg::DivNumW-1:0] w_num;
    logic [mta_pkg::DivDenW-1:0] w_den;
    logic                        w_div_done;
    logic [mta_pkg::DivNumW-1:0] w_quotient;

    assign w_deg_idx = 3'(i_cfg_index - 4'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tonic_offset <= mta_pkg::OffsetReset;
            for (int i = 0; i < mta_pkg::NumDeg; i++) begin
                r_deg[i] <= mta_pkg::DegreeReset[i];
            end
            r_prev_note  <= '0;
            r_prev_level <= mta_pkg::LevelChromatic;
        end else begin
            if (i_cfg_we) begin
                priority if (i_cfg_index == mta_pkg::REG_TONIC_OFFSET) begin
                    r_tonic_offset <= i_cfg_data;
                end else if (i_cfg_index <= mta_pkg::REG_SEVENTH_PC) begin
                    r_deg[w_deg_idx] <= i_cfg_data;
                end else begin
                    // indexes above seven are not mapped
                end
            end
            if (i_cmd.prep) begin
                r_prev_note  <= r_note;
                r_prev_level <= w_s2;
            end
        end
    end

    always_comb begin
        w_interval = {1'b0, r_note} - {1'b0, r_prev_note};
        w_abs      = w_interval[mta_pkg::IntvW-1] ? (8'd0 - w_interval) : w_interval;
        w_span     = (w_abs[PrevW-1:0] == '0) ? 7'd1 : w_abs[PrevW-1:0];

        // true mod 12 via reciprocal: x stays below 152, so the estimate is exact
        w_x     = {2'b00, r_note} + TwoOctaves - {5'b0, r_tonic_offset};
        w_prod  = {8'b0, w_x} * Recip12;
        w_quo   = w_prod[RecipShift+3:RecipShift];
        w_q12   = {5'b0, w_quo} * Semis;
        w_rem   = w_x - w_q12;
        w_pc    = w_rem[PcW-1:0];

        priority if (w_pc == r_deg[0]) begin
            w_s2 = mta_pkg::LevelOctave;
        end else if (w_pc == r_deg[2] || w_pc == r_deg[4]) begin
            w_s2 = mta_pkg::LevelTriadic;
        end else if (w_pc == r_deg[1] || w_pc == r_deg[3] ||
                     w_pc == r_deg[5] || w_pc == r_deg[6]) begin
            w_s2 = mta_pkg::LevelDiatonic;
        end else begin
            w_s2 = mta_pkg::LevelChromatic;
        end

        w_s1   = (r_prev_level == '0) ? mta_pkg::LevelChromatic : r_prev_level;
        w_s2sq = {2'b00, w_s2} * {2'b00, w_s2};
        w_s1sq = {2'b00, w_s1} * {2'b00, w_s1};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_note <= i_note_number[7] ? '0 : i_note_number[PrevW-1:0];
        end
        if (i_cmd.prep) begin
            r_pc       <= w_pc;
            r_s2       <= w_s2;
            r_s1       <= w_s1;
            r_s2sq     <= w_s2sq;
            r_s1sq     <= w_s1sq;
            r_span     <= w_span;
            r_interval <= w_interval;
        end
    end

    // divider operands
    always_comb begin
        w_s1d   = {7'b0, r_s1} * {3'b0, r_span};
        w_s1sqd = {7'b0, r_s1sq} * {5'b0, r_span};
        unique case (i_cmd.div_op)
            mta_pkg::OP_RATIO: begin
                w_num = {r_s2sq, 16'b0};
                w_den = {6'b0, r_s1sq};
            end
            mta_pkg::OP_RBI: begin
                w_num = {r_s2sq, 16'b0};
                w_den = w_s1sqd[mta_pkg::DivDenW-1:0];
            end
            default: begin
                w_num = {2'b00, r_s2, 16'b0};
                w_den = {1'b0, w_s1d};
            end
        endcase
    end

    mta_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_num),
        .i_divisor  (w_den),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            unique case (i_cmd.div_op)
                mta_pkg::OP_RATIO: r_q_ratio   <= w_quotient;
                mta_pkg::OP_RBI:   r_q_rbi     <= w_quotient;
                default:           r_q_tension <= w_quotient;
            endcase
        end
        if (i_cmd.load_out) begin
            o_pitch_class       <= r_pc;
            o_space_level       <= r_s2;
            o_closure           <= (r_s2 >= r_s1);
            o_tension           <= r_q_tension;
            o_level_ratio       <= r_q_ratio;
            o_ratio_by_interval <= r_q_rbi;
            o_interval          <= r_interval;
        end
    end

    assign o_status.div_done = w_div_done;

endmodule

`default_nettype wire

// File: hw/rtl/mta_ctrl.sv
// Controller: sequences capture, classification, three divisions and the output register.
`default_nettype none

module mta_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output mta_pkg::t_ctrl_cmd        o_cmd,
    input  wire mta_pkg::t_dp_status  i_status
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV_T,
        S_DIV_R,
        S_DIV_B,
        S_HOLD
    } t_state;

    t_state           r_state;
    logic             r_out_valid;
    logic             r_div_start;
    mta_pkg::t_div_op r_div_op;
    logic             w_out_free;

    always_comb begin
        o_ready         = (r_state == S_IDLE);
        w_out_free      = !r_out_valid || i_ready;
        o_cmd.capture   = i_valid && o_ready;
        o_cmd.prep      = (r_state == S_PREP);
        o_cmd.div_start = r_div_start;
        o_cmd.div_op    = r_div_op;
        o_cmd.load_out  = (r_state == S_HOLD) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
            r_div_op    <= mta_pkg::OP_TENSION;
        end else begin
            r_div_start <= 1'b0;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.capture) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_state     <= S_DIV_T;
                    r_div_start <= 1'b1;
                    r_div_op    <= mta_pkg::OP_TENSION;
                end
                S_DIV_T: begin
                    if (i_status.div_done) begin
                        r_state     <= S_DIV_R;
                        r_div_start <= 1'b1;
                        r_div_op    <= mta_pkg::OP_RATIO;
                    end
                end
                S_DIV_R: begin
                    if (i_status.div_done) begin
                        r_state     <= S_DIV_B;
                        r_div_start <= 1'b1;
                        r_div_op    <= mta_pkg::OP_RBI;
                    end
                end
                S_DIV_B: begin
                    if (i_status.div_done) r_state <= S_HOLD;
                end
                S_HOLD: begin
                    // waits only while the previous word is still unread
                    if (w_out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: hw/rtl/melodic_tension_analyzer_core.sv
// Melodic tension analyser top level: controller, datapath and port assertions.
// Each word passes through classification, then three divisions in one shared divider
// that resolves two quotient bits a cycle.
// No new word is taken while one is in flight; one is taken while the last result waits.
// Reset (synchronous, active low) restores the register reset values, previous note 0
// and previous level 1, and empties the output register.
`default_nettype none
`include "melodic_tension_analyzer_core_defines.svh"

module melodic_tension_analyzer_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic [mta_pkg::NoteW-1:0]         i_note_number,
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic [mta_pkg::PcW-1:0]                o_pitch_class,
    output logic [mta_pkg::LevelW-1:0]             o_space_level,
    output logic                                   o_closure,
    output logic [mta_pkg::FixW-1:0]               o_tension,
    output logic [mta_pkg::FixW-1:0]               o_level_ratio,
    output logic [mta_pkg::FixW-1:0]               o_ratio_by_interval,
    output logic signed [mta_pkg::IntvW-1:0]       o_interval,
    input  wire logic                              i_cfg_we,
    input  wire logic [mta_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  wire logic [mta_pkg::CfgDataW-1:0]      i_cfg_data
);

    mta_pkg::t_ctrl_cmd  w_cmd;
    mta_pkg::t_dp_status w_status;

    mta_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    mta_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_note_number       (i_note_number),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .o_pitch_class       (o_pitch_class),
        .o_space_level       (o_space_level),
        .o_closure           (o_closure),
        .o_tension           (o_tension),
        .o_level_ratio       (o_level_ratio),
        .o_ratio_by_interval (o_ratio_by_interval),
        .o_interval          (o_interval)
    );

    // a word in flight blocks the input side
    `MTA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `MTA_ASSERT_IMPLIES(a_level_range, i_clk, i_rst_n, o_valid, (o_space_level != 3'd0) && (o_space_level <= 3'd4))
    `MTA_ASSERT_IMPLIES(a_pc_range, i_clk, i_rst_n, o_valid, o_pitch_class < 4'd12)
    // smallest squared ratio is 1/16
    `MTA_ASSERT_IMPLIES(a_ratio_floor, i_clk, i_rst_n, o_valid, o_level_ratio >= 21'd4096)

endmodule

`default_nettype wire
